@@ hdl/omw_pkg.sv @@
// shared constants, types and cosine table for the omni wheel mixer
package omw_pkg;

   // wheel count in use and the number of wheel ports
   localparam int WHEELS     = 4;
   localparam int MAX_WHEELS = 4;

   // fixed-point widths
   localparam int MAG_W   = 18;              // |v| with 8 fraction bits
   localparam int QUOT_W  = 16;              // scaled magnitude, at most 255.0
   localparam int DVD_W   = MAG_W + QUOT_W;  // |v| * full scale
   localparam int ANGLE_W = 9;

   // register stages from acceptance to result: 4 front end, peak, scale
   // product, one per quotient bit and the output register
   localparam int PIPE_DEPTH = 7 + QUOT_W;

   // 255.0 with 8 fraction bits
   localparam logic [QUOT_W-1:0] FULL_SCALE = 16'd65280;

   // direction codes
   localparam logic [1:0] DRIVE_STOP    = 2'd0;
   localparam logic [1:0] DRIVE_FORWARD = 2'd1;
   localparam logic [1:0] DRIVE_REVERSE = 2'd2;

   // register indexes
   localparam logic [1:0] REG_MOUNT_0 = 2'd0;
   localparam logic [1:0] REG_MOUNT_1 = 2'd1;
   localparam logic [1:0] REG_MOUNT_2 = 2'd2;
   localparam logic [1:0] REG_MOUNT_3 = 2'd3;

   // per wheel result of the front end
   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] mag;
   } wheel_type;

   // data that rides along the divider
   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] mag;
      logic             scale;
   } div_side_type;

   // round(32768*cos(d)) for d = 0..90, saturated to 32767, Q1.15
   localparam logic [15:0] COS_TABLE [0:90] = '{
      16'd32767, 16'd32763, 16'd32748, 16'd32723, 16'd32688, 16'd32643, 16'd32588,
      16'd32524, 16'd32449, 16'd32365, 16'd32270, 16'd32166, 16'd32052, 16'd31928,
      16'd31795, 16'd31651, 16'd31499, 16'd31336, 16'd31164, 16'd30983, 16'd30792,
      16'd30592, 16'd30382, 16'd30163, 16'd29935, 16'd29698, 16'd29452, 16'd29197,
      16'd28932, 16'd28660, 16'd28378, 16'd28088, 16'd27789, 16'd27482, 16'd27166,
      16'd26842, 16'd26510, 16'd26170, 16'd25822, 16'd25466, 16'd25102, 16'd24730,
      16'd24351, 16'd23965, 16'd23571, 16'd23170, 16'd22763, 16'd22348, 16'd21926,
      16'd21498, 16'd21063, 16'd20622, 16'd20174, 16'd19720, 16'd19261, 16'd18795,
      16'd18324, 16'd17847, 16'd17364, 16'd16877, 16'd16384, 16'd15886, 16'd15384,
      16'd14876, 16'd14365, 16'd13848, 16'd13328, 16'd12803, 16'd12275, 16'd11743,
      16'd11207, 16'd10668, 16'd10126, 16'd9580,  16'd9032,  16'd8481,  16'd7927,
      16'd7371,  16'd6813,  16'd6252,  16'd5690,  16'd5126,  16'd4560,  16'd3993,
      16'd3425,  16'd2856,  16'd2286,  16'd1715,  16'd1144,  16'd572,   16'd0
   };

endpackage

@@ hdl/omw_lane.sv @@
// per wheel front end: angle, cosine lookup, product, rounding and correction
module omw_lane (
   input  logic                            clock,
   input  logic                            advance,
   input  logic [7:0]                      speed,
   input  logic [omw_pkg::ANGLE_W-1:0]     heading,
   input  logic signed [8:0]               correction,
   input  logic [omw_pkg::ANGLE_W-1:0]     mount_angle,
   output omw_pkg::wheel_type              wheel
);
   import omw_pkg::*;

   logic [ANGLE_W-1:0] angle_ff, angle_in;
   logic [7:0]         speed1_ff, speed2_ff;
   logic signed [8:0]  corr1_ff, corr2_ff, corr3_ff;
   logic signed [16:0] cos_ff, cos_in;
   logic signed [24:0] prod_ff, prod_in;
   wheel_type          wheel_ff, wheel_in;

   logic [9:0]         sum;
   logic [ANGLE_W-1:0] idx;
   logic               cos_neg;
   logic signed [25:0] prod_full;
   logic [22:0]        prod_mag;
   logic [15:0]        rnd;
   logic signed [18:0] rnd_s, corr_s, v;

   // angle sum reduced mod 360
   always_comb begin
      sum = {1'b0, heading} + {1'b0, mount_angle};
      if (sum >= 10'd720) begin
         angle_in = ANGLE_W'(sum - 10'd720);
      end else if (sum >= 10'd360) begin
         angle_in = ANGLE_W'(sum - 10'd360);
      end else begin
         angle_in = sum[ANGLE_W-1:0];
      end
   end

   // quarter-wave fold and table read
   always_comb begin
      if (angle_ff <= 9'd90) begin
         idx = angle_ff;
         cos_neg = 1'b0;
      end else if (angle_ff <= 9'd180) begin
         idx = 9'd180 - angle_ff;
         cos_neg = 1'b1;
      end else if (angle_ff <= 9'd270) begin
         idx = angle_ff - 9'd180;
         cos_neg = 1'b1;
      end else begin
         idx = 9'd360 - angle_ff;
         cos_neg = 1'b0;
      end
      cos_in = cos_neg ? -$signed({1'b0, COS_TABLE[idx[6:0]]})
                       :  $signed({1'b0, COS_TABLE[idx[6:0]]});
   end

   // cosine times speed
   always_comb begin
      prod_full = cos_ff * $signed({1'b0, speed2_ff});
      prod_in   = prod_full[24:0];
   end

   // round to 8 fraction bits and add correction
   always_comb begin
      prod_mag = prod_ff[24] ? 23'(-prod_ff) : prod_ff[22:0];
      rnd      = 16'((24'(prod_mag) + 24'd64) >> 7);
      rnd_s    = prod_ff[24] ? -$signed({3'b0, rnd}) : $signed({3'b0, rnd});
      corr_s   = $signed({{2{corr3_ff[8]}}, corr3_ff, 8'b0});
      v        = rnd_s + corr_s;
      wheel_in.neg = v[18];
      wheel_in.mag = v[18] ? MAG_W'(-v) : v[MAG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         angle_ff  <= angle_in;
         speed1_ff <= speed;
         corr1_ff  <= correction;
         cos_ff    <= cos_in;
         speed2_ff <= speed1_ff;
         corr2_ff  <= corr1_ff;
         prod_ff   <= prod_in;
         corr3_ff  <= corr2_ff;
         wheel_ff  <= wheel_in;
      end
   end

   assign wheel = wheel_ff;

endmodule

@@ hdl/omw_div.sv @@
// pipelined restoring divider, one quotient bit per stage
module omw_div (
   input  logic                          clock,
   input  logic                          advance,
   input  logic [omw_pkg::DVD_W-1:0]     dividend,
   input  logic [omw_pkg::MAG_W-1:0]     divisor,
   input  omw_pkg::div_side_type         side_in,
   output logic [omw_pkg::QUOT_W-1:0]    quotient,
   output omw_pkg::div_side_type         side_out
);
   import omw_pkg::*;

   logic [MAG_W-1:0]  rem_ff  [QUOT_W];
   logic [MAG_W-1:0]  rem_in  [QUOT_W];
   logic [QUOT_W-1:0] low_ff  [QUOT_W];
   logic [QUOT_W-1:0] quo_ff  [QUOT_W];
   logic [QUOT_W-1:0] quo_in  [QUOT_W];
   logic [MAG_W-1:0]  dsr_ff  [QUOT_W];
   div_side_type      side_ff [QUOT_W];

   logic [MAG_W-1:0]  src_rem [QUOT_W];
   logic [QUOT_W-1:0] src_low [QUOT_W];
   logic [QUOT_W-1:0] src_quo [QUOT_W];
   logic [MAG_W-1:0]  src_dsr [QUOT_W];
   div_side_type      src_side [QUOT_W];
   logic [MAG_W:0]    trial   [QUOT_W];
   logic              ge      [QUOT_W];

   // each stage shifts in one dividend bit and subtracts when it fits
   always_comb begin
      for (int i = 0; i < QUOT_W; i++) begin
         if (i == 0) begin
            src_rem[i]  = dividend[DVD_W-1:QUOT_W];
            src_low[i]  = dividend[QUOT_W-1:0];
            src_quo[i]  = '0;
            src_dsr[i]  = divisor;
            src_side[i] = side_in;
         end else begin
            src_rem[i]  = rem_ff[i-1];
            src_low[i]  = low_ff[i-1];
            src_quo[i]  = quo_ff[i-1];
            src_dsr[i]  = dsr_ff[i-1];
            src_side[i] = side_ff[i-1];
         end
         trial[i]  = {src_rem[i], src_low[i][QUOT_W-1-i]};
         ge[i]     = trial[i] >= {1'b0, src_dsr[i]};
         rem_in[i] = ge[i] ? MAG_W'(trial[i] - {1'b0, src_dsr[i]}) : trial[i][MAG_W-1:0];
         quo_in[i] = src_quo[i];
         quo_in[i][QUOT_W-1-i] = ge[i];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < QUOT_W; i++) begin
            rem_ff[i]  <= rem_in[i];
            low_ff[i]  <= src_low[i];
            quo_ff[i]  <= quo_in[i];
            dsr_ff[i]  <= src_dsr[i];
            side_ff[i] <= src_side[i];
         end
      end
   end

   assign quotient = quo_ff[QUOT_W-1];
   assign side_out = side_ff[QUOT_W-1];

endmodule

@@ hdl/omni_wheel_motor_mixer_unit.sv @@
// top level of the omni wheel motor mixer
// Four-wheel omni drive mixer. Each command (speed, heading, correction) gives one
// item of duty and direction for every wheel, computed as cos(heading + mount angle)
// times speed plus correction in fixed point, scaled down by 255/largest when any
// wheel exceeds full scale. A new command is taken every cycle unless a finished
// result waits unread; each one passes through 4 front-end stages, the peak search,
// the scale product, the 16-stage quotient pipeline of the scaling divider and the
// output register.
// The whole pipeline holds while a finished result waits; mount angles are written
// through the csr port and take effect for commands accepted afterwards.
module omni_wheel_motor_mixer_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_speed,
   input  logic [omw_pkg::ANGLE_W-1:0] req_heading,
   input  logic signed [8:0]           req_correction,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [7:0]                  rsp_duty_0,
   output logic [7:0]                  rsp_duty_1,
   output logic [7:0]                  rsp_duty_2,
   output logic [7:0]                  rsp_duty_3,
   output logic [1:0]                  rsp_drive_0,
   output logic [1:0]                  rsp_drive_1,
   output logic [1:0]                  rsp_drive_2,
   output logic [1:0]                  rsp_drive_3,
   input  logic                        csr_we,
   input  logic [1:0]                  csr_index,
   input  logic [omw_pkg::ANGLE_W-1:0] csr_wdata
);
   import omw_pkg::*;

   logic [PIPE_DEPTH-1:0] valid_ff, valid_in;
   logic               advance;
   logic [ANGLE_W-1:0] mount_ff [MAX_WHEELS];

   wheel_type          lane_out [MAX_WHEELS];
   wheel_type          wheel    [MAX_WHEELS];
   wheel_type          pk_ff    [MAX_WHEELS];
   logic [MAG_W-1:0]   peak_in, peak_ff, peak01, peak23;
   logic [DVD_W-1:0]   dvd_ff   [MAX_WHEELS];
   logic [DVD_W-1:0]   dvd_in   [MAX_WHEELS];
   div_side_type       side_ff  [MAX_WHEELS];
   logic [MAG_W-1:0]   dsr_ff;
   logic [QUOT_W-1:0]  quo      [MAX_WHEELS];
   div_side_type       side_out [MAX_WHEELS];
   logic [7:0]         duty_ff  [MAX_WHEELS];
   logic [7:0]         duty_in  [MAX_WHEELS];
   logic [1:0]         drive_ff [MAX_WHEELS];
   logic [1:0]         drive_in [MAX_WHEELS];
   logic [MAG_W-1:0]   fin_mag  [MAX_WHEELS];
   logic [MAG_W:0]     fin_rnd  [MAX_WHEELS];

   // whole pipeline holds only when a result is waiting
   assign advance   = !valid_ff[PIPE_DEPTH-1] || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = valid_ff[PIPE_DEPTH-1];
   assign valid_in  = {valid_ff[PIPE_DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // mount angle registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mount_ff[0] <= 9'd45;
         mount_ff[1] <= 9'd135;
         mount_ff[2] <= 9'd225;
         mount_ff[3] <= 9'd315;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_MOUNT_0: mount_ff[0] <= csr_wdata;
            REG_MOUNT_1: mount_ff[1] <= csr_wdata;
            REG_MOUNT_2: mount_ff[2] <= csr_wdata;
            REG_MOUNT_3: mount_ff[3] <= csr_wdata;
            default:     ;
         endcase
      end
   end

   // wheel front ends, unused wheels forced to zero
   for (genvar w = 0; w < MAX_WHEELS; w++) begin : g_lane
      omw_lane u_lane (
         .clock       (clock),
         .advance     (advance),
         .speed       (req_speed),
         .heading     (req_heading),
         .correction  (req_correction),
         .mount_angle (mount_ff[w]),
         .wheel       (lane_out[w])
      );
      assign wheel[w] = (w < WHEELS) ? lane_out[w] : '0;
   end

   // largest magnitude over the wheels
   always_comb begin
      peak01  = (wheel[0].mag > wheel[1].mag) ? wheel[0].mag : wheel[1].mag;
      peak23  = (wheel[2].mag > wheel[3].mag) ? wheel[2].mag : wheel[3].mag;
      peak_in = (peak01 > peak23) ? peak01 : peak23;
   end

   // magnitude times full scale as the divider's numerator
   always_comb begin
      for (int w = 0; w < MAX_WHEELS; w++) begin
         dvd_in[w] = DVD_W'(pk_ff[w].mag) * DVD_W'(FULL_SCALE);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         peak_ff <= peak_in;
         dsr_ff  <= peak_ff;
         for (int w = 0; w < MAX_WHEELS; w++) begin
            pk_ff[w]         <= wheel[w];
            dvd_ff[w]        <= dvd_in[w];
            side_ff[w].neg   <= pk_ff[w].neg;
            side_ff[w].mag   <= pk_ff[w].mag;
            side_ff[w].scale <= peak_ff > MAG_W'(FULL_SCALE);
         end
      end
   end

   // scaling dividers
   for (genvar w = 0; w < MAX_WHEELS; w++) begin : g_div
      omw_div u_div (
         .clock    (clock),
         .advance  (advance),
         .dividend (dvd_ff[w]),
         .divisor  (dsr_ff),
         .side_in  (side_ff[w]),
         .quotient (quo[w]),
         .side_out (side_out[w])
      );
   end

   // final rounding, clamp and direction
   always_comb begin
      for (int w = 0; w < MAX_WHEELS; w++) begin
         fin_mag[w] = side_out[w].scale ? MAG_W'(quo[w]) : side_out[w].mag;
         fin_rnd[w] = {1'b0, fin_mag[w]} + (MAG_W+1)'(128);
         duty_in[w] = (fin_rnd[w][MAG_W:8] > 11'd255) ? 8'd255 : fin_rnd[w][15:8];
         if (fin_mag[w] == '0) begin
            drive_in[w] = DRIVE_STOP;
         end else if (side_out[w].neg) begin
            drive_in[w] = DRIVE_REVERSE;
         end else begin
            drive_in[w] = DRIVE_FORWARD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int w = 0; w < MAX_WHEELS; w++) begin
            duty_ff[w]  <= duty_in[w];
            drive_ff[w] <= drive_in[w];
         end
      end
   end

   assign rsp_duty_0  = duty_ff[0];
   assign rsp_duty_1  = duty_ff[1];
   assign rsp_duty_2  = duty_ff[2];
   assign rsp_duty_3  = duty_ff[3];
   assign rsp_drive_0 = drive_ff[0];
   assign rsp_drive_1 = drive_ff[1];
   assign rsp_drive_2 = drive_ff[2];
   assign rsp_drive_3 = drive_ff[3];

endmodule

@@ dv/tb_omni_wheel_motor_mixer_unit.sv @@
// testbench for the omni wheel mixer: queued driver, clocked monitor, fixed-point predictor
module tb_omni_wheel_motor_mixer_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import omw_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [7:0]          req_speed = '0;
   logic [ANGLE_W-1:0]  req_heading = '0;
   logic signed [8:0]   req_correction = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [7:0]          rsp_duty_0, rsp_duty_1, rsp_duty_2, rsp_duty_3;
   logic [1:0]          rsp_drive_0, rsp_drive_1, rsp_drive_2, rsp_drive_3;
   logic                csr_we = 1'b0;
   logic [1:0]          csr_index = '0;
   logic [ANGLE_W-1:0]  csr_wdata = '0;

   typedef struct packed {
      logic [7:0]         speed;
      logic [ANGLE_W-1:0] heading;
      logic [8:0]         corr;
   } command_type;

   typedef struct packed {
      logic [3:0][7:0] duty;
      logic [3:0][1:0] drive;
   } mix_type;

   command_type        cmd_queue[$];
   mix_type            mix_expected[$];
   logic [ANGLE_W-1:0] mount[4];
   int                 mismatches = 0;
   bit                 quiet = 1'b0;      // no idling in the last part
   bit                 hold_off = 1'b0;   // long receiver stall request
   int                 send_gap = 0;
   int                 recv_gap = 0;
   int                 hold_count = 0;

   omni_wheel_motor_mixer_unit dut (.*);

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // quarter-wave cosine lookup
   function automatic longint cos_lookup(int deg);
      int a;
      a = deg % 360;
      if (a <= 90) return COS_TABLE[a];
      if (a <= 180) return -longint'(COS_TABLE[180 - a]);
      if (a <= 270) return -longint'(COS_TABLE[a - 180]);
      return COS_TABLE[360 - a];
   endfunction

   function automatic longint round_shift(longint x, int s);
      longint mag;
      mag = (x < 0) ? -x : x;
      mag = (mag + (longint'(1) << (s - 1))) >>> s;
      return (x < 0) ? -mag : mag;
   endfunction

   // wheel mix of one command
   function automatic mix_type mix_wheels(command_type c);
      longint v[4];
      longint corr, largest, m, d;
      mix_type r;
      corr = c.corr[8] ? longint'(c.corr) - 512 : longint'(c.corr);
      largest = 0;
      r = '0;
      for (int i = 0; i < WHEELS; i++) begin
         v[i] = round_shift(cos_lookup(int'(c.heading) + int'(mount[i])) * c.speed, 7)
                + corr * 256;
         m = (v[i] < 0) ? -v[i] : v[i];
         if (m > largest) largest = m;
      end
      for (int i = 0; i < WHEELS; i++) begin
         if (largest > 65280) v[i] = (v[i] * 65280) / largest;
         m = (v[i] < 0) ? -v[i] : v[i];
         d = round_shift(m, 8);
         if (d > 255) d = 255;
         r.duty[i] = d[7:0];
         r.drive[i] = (v[i] > 0) ? DRIVE_FORWARD : (v[i] < 0) ? DRIVE_REVERSE : DRIVE_STOP;
      end
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            mix_expected.push_back(mix_wheels(cmd_queue.pop_front()));
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if ((req_valid && req_ready ? cmd_queue.size() > 0
                                                 : cmd_queue.size() > 0)) begin
               if (!quiet && $urandom_range(0, 9) == 0) begin
                  send_gap <= $urandom_range(1, 14);
                  req_valid <= 1'b0;
               end else begin
                  req_valid <= 1'b1;
                  req_speed <= cmd_queue[0].speed;
                  req_heading <= cmd_queue[0].heading;
                  req_correction <= cmd_queue[0].corr;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver stalls
   always @(posedge clock) begin
      mix_type got, want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got.duty = {rsp_duty_3, rsp_duty_2, rsp_duty_1, rsp_duty_0};
            got.drive = {rsp_drive_3, rsp_drive_2, rsp_drive_1, rsp_drive_0};
            if (mix_expected.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) $display("unexpected item %h", got);
            end else begin
               want = mix_expected.pop_front();
               if (got !== want) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display("mismatch: expected duty %h drive %h, got duty %h drive %h",
                              want.duty, want.drive, got.duty, got.drive);
               end
            end
         end
         if (hold_off && hold_count == 0) begin
            hold_count <= 300;
            rsp_ready <= 1'b0;
         end else if (hold_count > 1) begin
            hold_count <= hold_count - 1;
         end else if (hold_count == 1) begin
            hold_count <= -1;
            rsp_ready <= 1'b1;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_ready <= (recv_gap == 1);
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            recv_gap <= $urandom_range(1, 14);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic write_mount(logic [1:0] idx, logic [ANGLE_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      mount[idx] = val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      while (cmd_queue.size() > 0 || req_valid || mix_expected.size() > 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   function automatic command_type random_command();
      command_type c;
      c.speed = $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 1) * 255) : 8'($urandom);
      c.heading = $urandom_range(0, 7) == 0 ? 9'($urandom) : 9'($urandom_range(0, 359));
      c.corr = $urandom_range(0, 4) == 0 ? 9'($urandom_range(0, 1) ? 255 : 9'h101)
                                         : 9'($urandom);
      return c;
   endfunction

   // stimulus
   initial begin
      mount[0] = 45; mount[1] = 135; mount[2] = 225; mount[3] = 315;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // directed: field extremes, wrap, -256, zero and tiny values
      cmd_queue.push_back('{8'd0, 9'd0, 9'd0});
      cmd_queue.push_back('{8'd255, 9'd0, 9'd0});
      cmd_queue.push_back('{8'd255, 9'd359, 9'd255});
      cmd_queue.push_back('{8'd255, 9'd90, 9'h101});
      cmd_queue.push_back('{8'd255, 9'd45, 9'h100});
      cmd_queue.push_back('{8'd0, 9'd511, 9'h100});
      cmd_queue.push_back('{8'd128, 9'd360, 9'd1});
      cmd_queue.push_back('{8'd1, 9'd135, 9'd0});
      cmd_queue.push_back('{8'd1, 9'd180, 9'h1FF});
      cmd_queue.push_back('{8'd200, 9'd270, 9'h1FF});
      cmd_queue.push_back('{8'd255, 9'd225, 9'd255});
      cmd_queue.push_back('{8'd3, 9'd45, 9'h101});
      cmd_queue.push_back('{8'd170, 9'h155, 9'hAA});
      cmd_queue.push_back('{8'd85, 9'hAA, 9'h155});
      drain();
      // angle settings, extremes included
      for (int phase = 0; phase < 6; phase++) begin
         for (int i = 0; i < 4; i++) begin
            case (phase)
               0: write_mount(2'(i), 9'd0);
               1: write_mount(2'(i), 9'd359);
               2: write_mount(2'(i), 9'd511);
               3: write_mount(2'(i), 9'(i * 90));
               default: write_mount(2'(i), 9'($urandom));
            endcase
         end
         for (int n = 0; n < 250; n++) cmd_queue.push_back(random_command());
         if (phase == 2) hold_off = 1'b1;
         if (phase == 5) quiet = 1'b1;
         drain();
      end
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // timeout
   initial begin
      #5ms;
      $display("FAILURE");
      $finish;
   end
endmodule
